// ===== sv/dssb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssb_pkg
// Shared types and constants for the dual stack over one shared buffer.
// ----------------------------------------------------------------------------
package dssb_pkg;

    localparam int DEPTH  = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int DATA_W = 32;

    // request codes
    localparam logic [1:0] REQ_PUSH_LO = 2'd0;
    localparam logic [1:0] REQ_PUSH_HI = 2'd1;
    localparam logic [1:0] REQ_POP_LO  = 2'd2;
    localparam logic [1:0] REQ_POP_HI  = 2'd3;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [DATA_W-1:0] push_value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] pop_value;
        logic [1:0]               status;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic load_read;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic             need_read;
        logic             rsp_valid;
        logic [CNT_W-1:0] used;
    } stat_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

endpackage

// ===== sv/dssb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dssb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/dssb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssb_ctrl
// Sequencer: takes a request, waits out the store read on a successful pop.
// ----------------------------------------------------------------------------
module dssb_ctrl
    import dssb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_stall,
    input  logic  rsp_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   free;

    // output register is empty or hands its beat over this cycle
    assign free      = !stat.rsp_valid || !rsp_stall;
    assign req_stall = !((state_reg == S_IDLE) && free);

    assign cmd.accept    = req_valid && !req_stall;
    assign cmd.load_read = (state_reg == S_READ);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept && stat.need_read)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/dssb_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssb_datapath
// Stack counts, shared store and result register.
// ----------------------------------------------------------------------------
module dssb_datapath
    import dssb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  req_t  req,
    input  logic  rsp_stall,
    input  cmd_t  cmd,
    output stat_t stat,
    output rsp_t  rsp,
    output logic  rsp_valid
);

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    logic [CNT_W-1:0] lower_reg;
    logic [CNT_W-1:0] lower_next;
    logic [CNT_W-1:0] upper_reg;
    logic [CNT_W-1:0] upper_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    logic [CNT_W:0]   used;
    logic             full;
    logic             is_pop;
    logic             stack_empty;
    logic [CNT_W-1:0] addr_full;
    logic [ADDR_W-1:0] addr;
    logic             we;
    logic [DATA_W-1:0] rdata;
    logic             load_now;

    assign used   = {1'b0, lower_reg} + {1'b0, upper_reg};
    assign full   = used >= {1'b0, DEPTH_C};
    assign is_pop = req.req_type[1];

    always_comb
    begin
        case (req.req_type)
            REQ_PUSH_LO: addr_full = lower_reg;
            REQ_PUSH_HI: addr_full = DEPTH_C - ONE_C - upper_reg;
            REQ_POP_LO:  addr_full = lower_reg - ONE_C;
            default:     addr_full = DEPTH_C - upper_reg;
        endcase
    end
    assign addr = addr_full[ADDR_W-1:0];

    assign stack_empty = (req.req_type == REQ_POP_LO) ? (lower_reg == '0)
                                                      : (upper_reg == '0);

    assign stat.need_read = is_pop && !stack_empty;
    assign stat.rsp_valid = rsp_valid_reg;
    assign stat.used      = used[CNT_W-1:0];

    assign we = cmd.accept && !is_pop && !full;

    dssb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (addr),
        .wdata (req.push_value),
        .raddr (addr),
        .rdata (rdata)
    );

    always_comb
    begin
        lower_next = lower_reg;
        upper_next = upper_reg;
        if (cmd.accept)
        begin
            case (req.req_type)
                REQ_PUSH_LO: if (!full) lower_next = lower_reg + ONE_C;
                REQ_PUSH_HI: if (!full) upper_next = upper_reg + ONE_C;
                REQ_POP_LO:  if (!stack_empty) lower_next = lower_reg - ONE_C;
                default:     if (!stack_empty) upper_next = upper_reg - ONE_C;
            endcase
        end
    end

    // push and refused pop answer at once; a good pop answers after the read
    assign load_now = cmd.accept && !stat.need_read;

    always_comb
    begin
        rsp_next = rsp_reg;
        if (cmd.load_read)
        begin
            rsp_next.pop_value = rdata;
            rsp_next.status    = ST_DONE;
        end
        else if (load_now)
        begin
            rsp_next.pop_value = '0;
            if (is_pop)
            begin
                rsp_next.status = ST_EMPTY;
            end
            else if (full)
            begin
                rsp_next.status = ST_FULL;
            end
            else
            begin
                rsp_next.status = ST_DONE;
            end
        end
    end

    assign rsp_valid_next = load_now || cmd.load_read || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg     <= '0;
            upper_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            lower_reg     <= lower_next;
            upper_reg     <= upper_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

// ===== sv/dual_stack_shared_buffer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_stack_shared_buffer_core
// Two stacks in one 32-word store, one growing up and one growing down.
// ----------------------------------------------------------------------------
// usage:
//   req channel (req_valid / req_stall / req) carries one request per beat:
//   push or pop on the lower or the upper stack. rsp channel
//   (rsp_valid / rsp_stall / rsp) returns exactly one result per request,
//   in order: popped word and a status (done, full, empty).
//   a push or a refused pop is answered from the output register, loaded
//   as its beat is taken; a successful pop goes through the registered
//   store read first and then through the output register.
//   throughput: one push or refused pop per cycle while results are not
//   stalled; a successful pop holds req_stall while the store read is in
//   flight, so no new request is taken until its result is loaded.
//   a new request is taken while a result still waits, as long as that
//   result leaves the output register in the same cycle.
//   reset clears both stack counts and the output valid; store contents
//   are not cleared, no entry is read before it is pushed.
//   when rsp_stall is high the result holds, and req_stall rises until
//   the output register is free again.
// ----------------------------------------------------------------------------
module dual_stack_shared_buffer_core
    import dssb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    cmd_t  cmd;
    stat_t stat;

    dssb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    dssb_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .stat      (stat),
        .rsp       (rsp),
        .rsp_valid (rsp_valid)
    );

    // the two stacks never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.used <= CNT_W'(DEPTH))
    else $error("stack counts exceed store depth");

    // a good pop keeps the request side stalled while the read is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept && stat.need_read |=> !rsp_valid && req_stall)
    else $error("pop read cycle not held");

    // and its result follows right after the read
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept && stat.need_read |=> ##1 rsp_valid && rsp.status == ST_DONE)
    else $error("pop result missing");

    // refused requests carry a zero word
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_FULL || rsp.status == ST_EMPTY)
            |-> rsp.pop_value == '0)
    else $error("refused request returned a nonzero word");

endmodule

// ===== test/tb_dual_stack_shared_buffer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_stack_shared_buffer_core
// Self-checking bench for the shared-store dual stack. Requests go in over
// the req channel with random gaps. Results come back over the rsp channel
// under random stalls. An in-bench stack model predicts each result, and the
// results are compared in order.
// ----------------------------------------------------------------------------
module tb_dual_stack_shared_buffer_core;
    import dssb_pkg::*;

    localparam int RANDOM_ITEMS = 850;

    typedef struct {
        req_t beat;
        bit   hold;     // wait until all outstanding results are back
    } req_item_t;

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_stall = 1'b0;
    req_t req       = '0;
    logic req_stall;
    logic rsp_valid;
    rsp_t rsp;

    req_item_t request_q[$];
    rsp_t      expected_rsp_q[$];
    int        mismatch_count = 0;

    // stack model state
    logic [DATA_W-1:0] stack_words [DEPTH];
    int lower_words = 0;
    int upper_words = 0;

    int tx_gap     = 0;
    int tx_calm    = 0;
    int rx_left    = 0;
    int rx_calm    = 0;

    dual_stack_shared_buffer_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic rsp_t apply_request(input req_t r);
        rsp_t res;
        int   used;
        res  = '0;
        used = lower_words + upper_words;
        case (r.req_type)
            REQ_PUSH_LO, REQ_PUSH_HI:
            begin
                if (used >= DEPTH)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    if (r.req_type == REQ_PUSH_LO)
                    begin
                        stack_words[lower_words] = r.push_value;
                        lower_words++;
                    end
                    else
                    begin
                        stack_words[DEPTH - 1 - upper_words] = r.push_value;
                        upper_words++;
                    end
                    res.status = ST_DONE;
                end
            end
            REQ_POP_LO:
            begin
                if (lower_words == 0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    lower_words--;
                    res.pop_value = stack_words[lower_words];
                    res.status    = ST_DONE;
                end
            end
            default:
            begin
                if (upper_words == 0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    res.pop_value = stack_words[DEPTH - upper_words];
                    upper_words--;
                    res.status    = ST_DONE;
                end
            end
        endcase
        return res;
    endfunction

    // mostly short gaps, a few long ones, none while calm
    function automatic int pick_gap(input bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 25);
    endfunction

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_request(input logic [1:0] kind, input logic [DATA_W-1:0] word,
                                 input bit hold);
        req_item_t item;
        item.beat.req_type   = kind;
        item.beat.push_value = word;
        item.hold            = hold;
        request_q.push_back(item);
    endtask

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("mismatch at %0t ns: %s got %h expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            tx_gap    <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                expected_rsp_q.push_back(apply_request(req));
            if (!req_valid || !req_stall)
            begin
                if (tx_gap > 0)
                begin
                    req_valid <= 1'b0;
                    tx_gap    <= tx_gap - 1;
                end
                else if (request_q.size() == 0 ||
                         (request_q[0].hold && expected_rsp_q.size() != 0))
                begin
                    req_valid <= 1'b0;
                end
                else
                begin
                    if (tx_calm > 0)
                        tx_calm--;
                    else if ($urandom_range(0, 39) == 0)
                        tx_calm = $urandom_range(20, 60);
                    req       <= request_q[0].beat;
                    req_valid <= 1'b1;
                    tx_gap    <= pick_gap(tx_calm > 0);
                    request_q.pop_front();
                end
            end
        end
    end

    // result monitor and stall generator
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            rx_left   = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    report_mismatch("unexpected beat, pop_value", rsp.pop_value, '0);
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp.pop_value !== want.pop_value)
                        report_mismatch("pop_value", rsp.pop_value, want.pop_value);
                    if (rsp.status !== want.status)
                        report_mismatch("status", 32'(rsp.status), 32'(want.status));
                end
            end
            if (rx_left > 0)
            begin
                rsp_stall <= 1'b1;
                rx_left--;
            end
            else
            begin
                rsp_stall <= 1'b0;
                if (rx_calm > 0)
                    rx_calm--;
                else if ($urandom_range(0, 49) == 0)
                    rx_calm = $urandom_range(20, 80);
                rx_left = pick_gap(rx_calm > 0);
            end
        end
    end

    initial
    begin
        int produced;
        int burst;
        int side;
        logic [1:0] kind;

        // empty pops, extreme words on both stacks, then unwind
        queue_request(REQ_POP_LO, 32'hdead_beef, 1'b0);
        queue_request(REQ_POP_HI, 32'h1234_5678, 1'b0);
        queue_request(REQ_PUSH_LO, 32'h7fff_ffff, 1'b0);
        queue_request(REQ_PUSH_LO, 32'h8000_0000, 1'b0);
        queue_request(REQ_PUSH_LO, 32'h0000_0000, 1'b0);
        queue_request(REQ_PUSH_LO, 32'hffff_ffff, 1'b0);
        queue_request(REQ_PUSH_HI, 32'h8000_0000, 1'b0);
        queue_request(REQ_PUSH_HI, 32'h7fff_ffff, 1'b0);
        queue_request(REQ_PUSH_HI, 32'h5555_5555, 1'b0);
        queue_request(REQ_PUSH_HI, 32'haaaa_aaaa, 1'b0);
        repeat (4) queue_request(REQ_POP_HI, $urandom, 1'b0);
        repeat (4) queue_request(REQ_POP_LO, $urandom, 1'b0);
        queue_request(REQ_POP_LO, 32'hffff_ffff, 1'b0);
        queue_request(REQ_POP_HI, 32'hffff_ffff, 1'b0);

        // fill the store from both ends until it refuses pushes on either side
        produced = 0;
        for (int i = 0; i < DEPTH + 4; i++)
        begin
            kind = (i % 3 == 0) ? REQ_PUSH_HI : REQ_PUSH_LO;
            queue_request(kind, pick_word(), i == 0);
            produced++;
        end
        queue_request(REQ_PUSH_HI, pick_word(), 1'b0);
        queue_request(REQ_PUSH_LO, pick_word(), 1'b0);
        produced += 2;

        while (produced < RANDOM_ITEMS)
        begin
            side = $urandom_range(0, 2);
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    burst = $urandom_range(15, 40);
                    repeat (burst)
                    begin
                        kind = (side == 2) ? 2'($urandom_range(0, 1)) : 2'(side);
                        queue_request(kind == 0 ? REQ_PUSH_LO : REQ_PUSH_HI, pick_word(), 1'b0);
                    end
                end
                4, 5, 6:
                begin
                    burst = $urandom_range(15, 45);
                    repeat (burst)
                    begin
                        kind = (side == 2) ? 2'($urandom_range(0, 1)) : 2'(side);
                        queue_request(kind == 0 ? REQ_POP_LO : REQ_POP_HI, $urandom, 1'b0);
                    end
                end
                7, 8:
                begin
                    burst = $urandom_range(5, 20);
                    repeat (burst)
                        queue_request(2'($urandom_range(0, 3)), pick_word(), 1'b0);
                end
                default:
                begin
                    burst = 1;
                    queue_request(2'($urandom_range(0, 3)), pick_word(), 1'b1);
                end
            endcase
            produced += burst;
        end

        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (request_q.size() != 0 || req_valid || expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (expected_rsp_q.size() != 0)
            report_mismatch("results missing, count", expected_rsp_q.size(), 0);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
